>>> src/assert_macros.svh
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every rising clock edge
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// in the cycle after the trigger, the result holds
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> src/bctl_pkg.sv
// ----------------------------------------------------------------------------
// bctl_pkg
// types and codes shared by the cache tag controller and its entry cells
// ----------------------------------------------------------------------------
package bctl_pkg;

    localparam int C_CELL_IW = 6;

    localparam logic [2:0] OP_LOOKUP_ALLOC = 3'd0;
    localparam logic [2:0] OP_LOOKUP_ONLY  = 3'd1;
    localparam logic [2:0] OP_COMPLETE_OK  = 3'd2;
    localparam logic [2:0] OP_COMPLETE_ERR = 3'd3;
    localparam logic [2:0] OP_FLUSH_FILE   = 3'd4;
    localparam logic [2:0] OP_FLUSH_ALL    = 3'd5;

    localparam logic [2:0] ST_HIT_READY = 3'd0;
    localparam logic [2:0] ST_HIT_BUSY  = 3'd1;
    localparam logic [2:0] ST_ALLOC     = 3'd2;
    localparam logic [2:0] ST_NO_SLOT   = 3'd3;
    localparam logic [2:0] ST_MISS      = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_TOUCH,
        ACT_ALLOC,
        ACT_DONE_OK,
        ACT_CLEAR,
        ACT_FLUSH_FILE,
        ACT_FLUSH_ALL
    } t_act;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] file_id;
        logic [47:0] block_number;
        logic [3:0]  entry_index;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] result_index;
        logic [4:0] in_flight_count;
    } t_out;

    // broadcast to every cell for the whole pass
    typedef struct packed {
        logic        upd;
        t_act        act;
        logic [3:0]  tgt;
        logic [15:0] file;
        logic [47:0] block;
        logic [63:0] stamp;
        logic [3:0]  idx;
        logic [4:0]  n;
    } t_cmd;

    // travels from cell to cell with the token
    typedef struct packed {
        logic        found;
        logic [3:0]  hit_idx;
        logic        hit_busy;
        logic        have;
        logic [3:0]  vic_idx;
        logic [63:0] vic_stamp;
        logic        cok;
        logic [4:0]  cnt;
    } t_carry;

endpackage

>>> src/bctl_cell.sv
// ----------------------------------------------------------------------------
// bctl_cell
// one cache entry: tag compare, lru candidate and update on token arrival
// ----------------------------------------------------------------------------
module bctl_cell
    import bctl_pkg::*;
#(
    parameter int P_IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  logic   i_tok,
    input  t_carry i_carry,
    output logic   o_tok,
    output t_carry o_carry
);

    localparam logic [C_CELL_IW-1:0] L_IDX = C_CELL_IW'(P_IDX);

    logic        r_valid;
    logic [15:0] r_file;
    logic [47:0] r_block;
    logic        r_busy;
    logic [63:0] r_stamp;
    logic        r_tok;
    t_carry      r_carry;

    logic        n_valid;
    logic [15:0] n_file;
    logic [47:0] n_block;
    logic        n_busy;
    logic [63:0] n_stamp;
    t_carry      n_carry;

    logic active;
    logic sel;
    logic clr;

    assign active = L_IDX < {1'b0, i_cmd.n};
    assign sel    = {2'b00, i_cmd.tgt} == L_IDX;

    always_comb begin
        n_valid = r_valid;
        n_file  = r_file;
        n_block = r_block;
        n_busy  = r_busy;
        n_stamp = r_stamp;
        n_carry = i_carry;
        clr     = 1'b0;
        if (!i_cmd.upd) begin
            if (active && !i_carry.found && r_valid && r_file == i_cmd.file
                && r_block == i_cmd.block) begin
                n_carry.found    = 1'b1;
                n_carry.hit_idx  = L_IDX[3:0];
                n_carry.hit_busy = r_busy;
            end
            if (active && !r_busy && (!i_carry.have || r_stamp < i_carry.vic_stamp)) begin
                n_carry.have      = 1'b1;
                n_carry.vic_idx   = L_IDX[3:0];
                n_carry.vic_stamp = r_stamp;
            end
            if (active && {2'b00, i_cmd.idx} == L_IDX && r_valid && r_busy) begin
                n_carry.cok = 1'b1;
            end
        end else begin
            case (i_cmd.act)
                ACT_TOUCH: begin
                    if (sel) n_stamp = i_cmd.stamp;
                end
                ACT_ALLOC: begin
                    if (sel) begin
                        n_valid = 1'b1;
                        n_file  = i_cmd.file;
                        n_block = i_cmd.block;
                        n_busy  = 1'b1;
                        n_stamp = i_cmd.stamp;
                    end
                end
                ACT_DONE_OK: begin
                    if (sel) begin
                        n_stamp = i_cmd.stamp;
                        n_busy  = 1'b0;
                    end
                end
                ACT_CLEAR:      clr = sel;
                ACT_FLUSH_FILE: clr = active && r_valid && r_file == i_cmd.file;
                ACT_FLUSH_ALL:  clr = 1'b1;
                default:        clr = 1'b0;
            endcase
            if (clr) begin
                n_valid = 1'b0;
                n_file  = '0;
                n_block = '0;
                n_busy  = 1'b0;
                n_stamp = '0;
            end
            n_carry.cnt = i_carry.cnt + {4'd0, active && n_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_file  <= '0;
            r_block <= '0;
            r_busy  <= 1'b0;
            r_stamp <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_tok) begin
                r_valid <= n_valid;
                r_file  <= n_file;
                r_block <= n_block;
                r_busy  <= n_busy;
                r_stamp <= n_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) r_carry <= n_carry;
    end

    assign o_tok   = r_tok;
    assign o_carry = r_carry;

endmodule

>>> src/block_cache_tag_lru_manager.sv
// ----------------------------------------------------------------------------
// block_cache_tag_lru_manager
// tag side of a fully associative block cache with lru replacement
// ----------------------------------------------------------------------------
// For each request, a token walks the row of entry cells once to compare tags,
// pick the lru victim and check a completion, then walks it again to apply the
// update and count the in-flight entries. One request is in work at a time; the
// next is taken once the previous result sits in the output register.
module block_cache_tag_lru_manager
    import bctl_pkg::*;
#(
    parameter int NUM_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data
);

    `include "assert_macros.svh"

    localparam int L_LIM_I = (NUM_ENTRIES < 16) ? NUM_ENTRIES : 16;
    localparam logic [4:0] L_LIM = 5'(L_LIM_I);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE, S_FIN} t_state;

    t_state      r_state;
    logic [4:0]  r_cfg;
    logic [63:0] r_clock;
    logic        r_launch;
    t_cmd        r_cmd;
    logic [2:0]  r_op;
    logic [2:0]  r_status;
    logic [3:0]  r_ridx;
    logic [4:0]  r_cnt;
    logic        r_ov;
    t_out        r_out;

    logic   tok   [NUM_ENTRIES+1];
    t_carry carry [NUM_ENTRIES+1];
    logic [4:0] n_cnt;
    t_carry last;

    assign tok[0]   = r_launch;
    assign carry[0] = '0;
    assign last     = carry[NUM_ENTRIES];

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        bctl_cell #(.P_IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_tok   (tok[g]),
            .i_carry (carry[g]),
            .o_tok   (tok[g+1]),
            .o_carry (carry[g+1])
        );
    end

    always_comb begin
        if (r_cfg == 5'd0) n_cnt = 5'd1;
        else if (r_cfg > L_LIM) n_cnt = L_LIM;
        else n_cnt = r_cfg;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= 5'd16;
            r_clock  <= '0;
            r_launch <= 1'b0;
            r_ov     <= 1'b0;
            r_cmd    <= '0;
        end else begin
            r_launch <= (r_state == S_IDLE && i_in_valid)
                        || (r_state == S_SEARCH && tok[NUM_ENTRIES]);
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            if (r_ov && i_out_ready && r_state != S_FIN) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op        <= i_in_data.opcode;
                        r_cmd.upd   <= 1'b0;
                        r_cmd.act   <= ACT_NONE;
                        r_cmd.tgt   <= '0;
                        r_cmd.file  <= i_in_data.file_id;
                        r_cmd.block <= i_in_data.block_number;
                        r_cmd.stamp <= r_clock + 64'd1;
                        r_cmd.idx   <= i_in_data.entry_index;
                        r_cmd.n     <= n_cnt;
                        r_state     <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (tok[NUM_ENTRIES]) begin
                        r_cmd.upd <= 1'b1;
                        r_state   <= S_UPDATE;
                        case (r_op)
                            OP_LOOKUP_ALLOC, OP_LOOKUP_ONLY: begin
                                if (last.found) begin
                                    r_ridx <= last.hit_idx;
                                    if (last.hit_busy) begin
                                        r_status <= ST_HIT_BUSY;
                                    end else begin
                                        r_status  <= ST_HIT_READY;
                                        r_cmd.act <= ACT_TOUCH;
                                        r_cmd.tgt <= last.hit_idx;
                                        r_clock   <= r_cmd.stamp;
                                    end
                                end else if (r_op == OP_LOOKUP_ONLY) begin
                                    r_status <= ST_MISS;
                                    r_ridx   <= '0;
                                end else if (last.have) begin
                                    r_status  <= ST_ALLOC;
                                    r_ridx    <= last.vic_idx;
                                    r_cmd.act <= ACT_ALLOC;
                                    r_cmd.tgt <= last.vic_idx;
                                    r_clock   <= r_cmd.stamp;
                                end else begin
                                    r_status <= ST_NO_SLOT;
                                    r_ridx   <= '0;
                                end
                            end
                            OP_COMPLETE_OK: begin
                                r_status <= ST_DONE;
                                r_ridx   <= '0;
                                if (last.cok) begin
                                    r_cmd.act <= ACT_DONE_OK;
                                    r_cmd.tgt <= r_cmd.idx;
                                    r_clock   <= r_cmd.stamp;
                                end
                            end
                            OP_COMPLETE_ERR: begin
                                r_status <= ST_DONE;
                                r_ridx   <= '0;
                                if (last.cok) begin
                                    r_cmd.act <= ACT_CLEAR;
                                    r_cmd.tgt <= r_cmd.idx;
                                end
                            end
                            OP_FLUSH_FILE: begin
                                r_status  <= ST_DONE;
                                r_ridx    <= '0;
                                r_cmd.act <= ACT_FLUSH_FILE;
                            end
                            OP_FLUSH_ALL: begin
                                r_status  <= ST_DONE;
                                r_ridx    <= '0;
                                r_cmd.act <= ACT_FLUSH_ALL;
                            end
                            default: begin
                                r_status  <= ST_DONE;
                                r_ridx    <= '0;
                                r_cmd.act <= ACT_NONE;
                            end
                        endcase
                    end
                end
                S_UPDATE: begin
                    if (tok[NUM_ENTRIES]) begin
                        r_cnt   <= last.cnt;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov                  <= 1'b1;
                        r_out.status          <= r_status;
                        r_out.result_index    <= r_ridx;
                        r_out.in_flight_count <= r_cnt;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, !r_ov || r_out.in_flight_count <= L_LIM,
        "in-flight count above entry count")
    `ASSERT_ALWAYS(a_clock_step, $stable(r_clock) || r_clock == $past(r_clock) + 64'd1,
        "use clock moved by more than one")
    `ASSERT_NEXT(a_launch_after_xfer, i_in_valid && o_in_ready, r_launch && !o_in_ready,
        "search pass not started after input transfer")

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cache tag lru manager: a directed table, then
// random request streams over a small tag set, checked against a predictor
// ----------------------------------------------------------------------------
module tb_top;
    import bctl_pkg::*;

    localparam int NE = 16;
    localparam int WD_LIMIT = 2000;
    localparam int EXP_DEPTH = 64;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [4:0] i_cfg_data;

    block_cache_tag_lru_manager #(.NUM_ENTRIES(NE)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // predictor state
    logic        tag_valid [NE];
    logic [15:0] tag_file [NE];
    logic [47:0] tag_block [NE];
    logic        tag_busy [NE];
    logic [63:0] tag_stamp [NE];
    logic [63:0] lru_clock;
    logic [4:0]  active_reg;

    // expected results, written in order of prediction, read in order of transfer
    t_out exp_mem [EXP_DEPTH];
    int   exp_wr = 0;
    int   exp_rd = 0;
    int   errors = 0;
    int   idle_cycles = 0;

    // directed table: item, typed result, whether the result is typed in
    typedef struct packed {
        t_in  req;
        t_out res;
        logic fixed;
    } t_row;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int active_n();
        int n;
        n = int'(active_reg);
        if (n < 1) n = 1;
        if (n > NE) n = NE;
        return n;
    endfunction

    function automatic void clear_tag(int i);
        tag_valid[i] = 0; tag_file[i] = 0; tag_block[i] = 0;
        tag_busy[i] = 0; tag_stamp[i] = 0;
    endfunction

    function automatic void touch_tag(int i);
        lru_clock = lru_clock + 64'd1;
        tag_stamp[i] = lru_clock;
    endfunction

    function automatic void reset_tags();
        for (int i = 0; i < NE; i++) clear_tag(i);
        lru_clock = 0;
        active_reg = 5'd16;
    endfunction

    function automatic t_out predict_lookup(t_in r);
        t_out o;
        int n, hit, vic, cnt;
        n = active_n();
        hit = -1;
        vic = -1;
        cnt = 0;
        o.status = ST_DONE;
        o.result_index = 0;
        case (r.opcode)
            OP_LOOKUP_ALLOC, OP_LOOKUP_ONLY: begin
                for (int i = 0; i < n; i++)
                    if (hit < 0 && tag_valid[i] && tag_file[i] == r.file_id &&
                        tag_block[i] == r.block_number) hit = i;
                if (hit >= 0) begin
                    o.result_index = 4'(hit);
                    if (tag_busy[hit]) o.status = ST_HIT_BUSY;
                    else begin
                        touch_tag(hit);
                        o.status = ST_HIT_READY;
                    end
                end else if (r.opcode == OP_LOOKUP_ONLY) begin
                    o.status = ST_MISS;
                end else begin
                    for (int i = 0; i < n; i++)
                        if (!tag_busy[i] && (vic < 0 || tag_stamp[i] < tag_stamp[vic]))
                            vic = i;
                    if (vic >= 0) begin
                        tag_valid[vic] = 1; tag_file[vic] = r.file_id;
                        tag_block[vic] = r.block_number; tag_busy[vic] = 1;
                        touch_tag(vic);
                        o.status = ST_ALLOC;
                        o.result_index = 4'(vic);
                    end else o.status = ST_NO_SLOT;
                end
            end
            OP_COMPLETE_OK, OP_COMPLETE_ERR: begin
                if (r.entry_index < n && tag_valid[r.entry_index] &&
                    tag_busy[r.entry_index]) begin
                    if (r.opcode == OP_COMPLETE_OK) begin
                        touch_tag(r.entry_index);
                        tag_busy[r.entry_index] = 0;
                    end else clear_tag(r.entry_index);
                end
            end
            OP_FLUSH_FILE: begin
                for (int i = 0; i < n; i++)
                    if (tag_valid[i] && tag_file[i] == r.file_id) clear_tag(i);
            end
            OP_FLUSH_ALL: begin
                for (int i = 0; i < NE; i++) clear_tag(i);
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) if (tag_busy[i]) cnt++;
        o.in_flight_count = 5'(cnt);
        return o;
    endfunction

    function automatic t_in mk_req(logic [2:0] op, logic [15:0] f, logic [47:0] b,
                                   logic [3:0] idx);
        t_in r;
        r.opcode = op; r.file_id = f; r.block_number = b; r.entry_index = idx;
        return r;
    endfunction

    function automatic t_out mk_res(logic [2:0] st, logic [3:0] idx, logic [4:0] c);
        t_out o;
        o.status = st; o.result_index = idx; o.in_flight_count = c;
        return o;
    endfunction

    // random request: mostly a small pool of tags so hits and evictions happen
    function automatic t_in rand_req();
        t_in r;
        int k;
        k = $urandom_range(0, 99);
        r.file_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        r.block_number = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                                     : 48'($urandom_range(0, 11));
        r.entry_index = 4'($urandom);
        if (k < 40) r.opcode = OP_LOOKUP_ALLOC;
        else if (k < 55) r.opcode = OP_LOOKUP_ONLY;
        else if (k < 80) r.opcode = OP_COMPLETE_OK;
        else if (k < 91) r.opcode = OP_COMPLETE_ERR;
        else if (k < 96) r.opcode = OP_FLUSH_FILE;
        else if (k < 98) r.opcode = OP_FLUSH_ALL;
        else r.opcode = 3'($urandom_range(6, 7));
        // completions mostly aim at an in-flight entry
        if ((r.opcode == OP_COMPLETE_OK || r.opcode == OP_COMPLETE_ERR) &&
            $urandom_range(0, 3) != 0) begin
            for (int t = 0; t < 8; t++) begin
                k = $urandom_range(0, active_n() - 1);
                if (tag_busy[k]) begin
                    r.entry_index = 4'(k);
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic send_checked(input t_in r, input t_out typed, input logic fixed);
        t_out p;
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        p = predict_lookup(r);
        if (fixed && p != typed) report_mismatch("table row", int'(p), int'(typed));
        exp_mem[exp_wr % EXP_DEPTH] = p;
        exp_wr++;
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [4:0] v);
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (2 * NE + 8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        active_reg = v;
    endtask

    // result side
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected result transfer", 1, 0);
            end else begin
                want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.result_index !== want.result_index)
                    report_mismatch("result_index", o_out_data.result_index,
                                    want.result_index);
                if (o_out_data.in_flight_count !== want.in_flight_count)
                    report_mismatch("in_flight_count", o_out_data.in_flight_count,
                                    want.in_flight_count);
            end
        end
    end

    int out_wait = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            out_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
            i_out_ready <= (out_wait == 0);
        end else if (out_wait > 0) begin
            out_wait--;
            i_out_ready <= (out_wait == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    t_row dir_table[$];

    initial begin
        logic [4:0] sizes [8];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 5'd16;
        reset_tags();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_table = '{
            '{mk_req(OP_LOOKUP_ONLY, 16'h0, 48'h0, 4'h0), mk_res(ST_MISS, 0, 0), 1'b1},
            '{mk_req(OP_COMPLETE_OK, 16'h0, 48'h0, 4'h0), mk_res(ST_DONE, 0, 0), 1'b1},
            '{mk_req(OP_LOOKUP_ALLOC, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 4'hF),
              mk_res(ST_ALLOC, 0, 1), 1'b1},
            '{mk_req(OP_LOOKUP_ALLOC, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 4'h0),
              mk_res(ST_HIT_BUSY, 0, 1), 1'b1},
            '{mk_req(OP_LOOKUP_ALLOC, 16'h0, 48'h0, 4'h0), mk_res(ST_ALLOC, 1, 2), 1'b1},
            '{mk_req(OP_COMPLETE_OK, 16'h0, 48'h0, 4'h0), mk_res(ST_DONE, 0, 1), 1'b1},
            '{mk_req(OP_LOOKUP_ONLY, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 4'h0),
              mk_res(ST_HIT_READY, 0, 1), 1'b1},
            '{mk_req(OP_COMPLETE_ERR, 16'h0, 48'h0, 4'h1), mk_res(ST_DONE, 0, 0), 1'b1},
            '{mk_req(OP_COMPLETE_ERR, 16'h0, 48'h0, 4'hF), mk_res(ST_DONE, 0, 0), 1'b1},
            '{mk_req(3'd6, 16'h1, 48'h1, 4'h1), mk_res(ST_DONE, 0, 0), 1'b1},
            '{mk_req(3'd7, 16'h1, 48'h1, 4'h1), mk_res(ST_DONE, 0, 0), 1'b1},
            '{mk_req(OP_LOOKUP_ALLOC, 16'h5, 48'h2, 4'h0), '0, 1'b0},
            '{mk_req(OP_LOOKUP_ALLOC, 16'h5, 48'h3, 4'h0), '0, 1'b0},
            '{mk_req(OP_FLUSH_FILE, 16'h5, 48'h0, 4'h0), '0, 1'b0},
            '{mk_req(OP_LOOKUP_ALLOC, 16'h6, 48'h1, 4'h0), '0, 1'b0},
            '{mk_req(OP_FLUSH_ALL, 16'h0, 48'h0, 4'h0), mk_res(ST_DONE, 0, 0), 1'b1}
        };
        foreach (dir_table[k]) send_checked(dir_table[k].req, dir_table[k].res,
                                            dir_table[k].fixed);

        // fill every slot to reach the no free slot case
        for (int i = 0; i < NE; i++)
            send_checked(mk_req(OP_LOOKUP_ALLOC, 16'h9, 48'(i), 4'h0), '0, 1'b0);
        send_checked(mk_req(OP_LOOKUP_ALLOC, 16'h9, 48'h99, 4'h0),
                     mk_res(ST_NO_SLOT, 0, 16), 1'b1);

        // random phases over several sizes, extremes included
        sizes = '{5'd1, 5'd0, 5'd16, 5'd3, 5'd31, 5'd8, 5'd2, 5'd16};
        foreach (sizes[p]) begin
            write_active(sizes[p]);
            for (int k = 0; k < 190; k++) send_checked(rand_req(), '0, 1'b0);
        end
        i_in_valid <= 1'b0;

        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (2 * NE + 8) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/bctl_pkg.sv
src/bctl_cell.sv
src/block_cache_tag_lru_manager.sv
tb/tb_top.sv
